FILE: hdl/chba_pkg.sv
// Shared types and codes for the compacting handle byte allocator.
// No dependencies; used by every module of the block.
package chba_pkg;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_WRITE = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [1:0] ST_NO_HANDLE = 2'd2;
   localparam logic [1:0] ST_BAD       = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [10:0] alloc_size;
      logic [7:0]  handle;
      logic [9:0]  byte_offset;
      logic [7:0]  write_value;
   } req_type;

   typedef struct packed {
      logic [7:0] new_handle;
      logic [7:0] read_value;
      logic [1:0] status;
      logic       compacted;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOKUP,
      S_CHECK,
      S_ZERO,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SCAN_END,
      S_MOVE_RD,
      S_MOVE_WR,
      S_PLACE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic commit_alloc;
      logic commit_free;
      logic store_write;
      logic store_read;
      logic fill_step;
      logic scan_sel;
      logic scan_cmp;
      logic move_rd;
      logic move_wr;
      logic place;
      logic comp_done;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] code;
      logic       size_zero;
      logic       compact_hit;
      logic       scan_last;
      logic       found;
      logic       move_needed;
      logic       fill_last;
      logic       move_last;
   } stat_type;

endpackage

FILE: hdl/compacting_handle_byte_allocator_top.sv
// Top level of the compacting handle byte allocator.
// Depends on chba_pkg, chba_ctrl and chba_dp.
//
// Usage: drive req_payload and raise start; the transaction is taken at a
// rising edge with start high and busy low. Each transaction yields exactly
// one result on rsp_payload, shown for one cycle with rsp_strobe high; the
// receiver cannot stall it.
// Sequencing: a transaction may already be accepted in the strobe cycle of
// the one before. A successful alloc zero-fills each requested byte in turn
// (single-port byte store). A free that compacts walks the handle table once
// per live block plus once more, with one table read and one compare per
// slot, and places each live block; a block that must move has each byte
// read and then written through the single store port.
// Reset: synchronous; empties the free list, clears all live bits and the
// counters. Tables and byte store keep no reset value and need no clearing.
module compacting_handle_byte_allocator_top import chba_pkg::*; #(
   parameter int HANDLE_SLOTS = 256,
   parameter int STORE_BYTES  = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   cmd_type  cmd;
   stat_type stat;

   chba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   chba_dp #(
      .HANDLE_SLOTS (HANDLE_SLOTS),
      .STORE_BYTES  (STORE_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hdl/chba_ctrl.sv
// Sequencer for the allocator: one state machine driving the datapath.
// Depends on chba_pkg for state, command and status types.
module chba_ctrl import chba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_LOOKUP;
         end
         S_LOOKUP: state_in = S_CHECK;
         S_CHECK: begin
            if (stat.code != ST_OK) begin
               state_in = S_RESP;
            end else begin
               unique case (stat.action)
                  ACT_ALLOC: state_in = stat.size_zero ? S_RESP : S_ZERO;
                  ACT_FREE:  state_in = stat.compact_hit ? S_SCAN_RD : S_RESP;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_ZERO: begin
            if (stat.fill_last) state_in = S_RESP;
         end
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: state_in = stat.scan_last ? S_SCAN_END : S_SCAN_RD;
         S_SCAN_END: begin
            priority if (!stat.found) state_in = S_RESP;
            else if (stat.move_needed) state_in = S_MOVE_RD;
            else state_in = S_PLACE;
         end
         S_MOVE_RD: state_in = S_MOVE_WR;
         S_MOVE_WR: state_in = stat.move_last ? S_PLACE : S_MOVE_RD;
         S_PLACE: state_in = S_SCAN_RD;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: cmd.load = start;
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.code == ST_OK) begin
               cmd.commit_alloc = (stat.action == ACT_ALLOC);
               cmd.commit_free  = (stat.action == ACT_FREE);
               cmd.store_read   = (stat.action == ACT_READ);
               cmd.store_write  = (stat.action == ACT_WRITE);
            end
         end
         S_ZERO:     cmd.fill_step = 1'b1;
         S_SCAN_RD:  cmd.scan_sel = 1'b1;
         S_SCAN_CMP: cmd.scan_cmp = 1'b1;
         S_SCAN_END: cmd.comp_done = !stat.found;
         S_MOVE_RD:  cmd.move_rd = 1'b1;
         S_MOVE_WR:  cmd.move_wr = 1'b1;
         S_PLACE:    cmd.place = 1'b1;
         S_RESP:     cmd.respond = 1'b1;
         default:    cmd = '0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: hdl/chba_dp.sv
// Datapath for the allocator: handle tables, byte store, counters, result register.
// Depends on chba_pkg; commanded by chba_ctrl.
module chba_dp import chba_pkg::*; #(
   parameter int HANDLE_SLOTS = 256,
   parameter int STORE_BYTES  = 1024
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_payload,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_strobe,
   output rsp_type  rsp_payload
);

   localparam int HW  = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;
   localparam int CW  = $clog2(HANDLE_SLOTS + 1);
   localparam int SAW = $clog2(STORE_BYTES);
   localparam int OW  = $clog2(STORE_BYTES + 1);
   localparam int EW  = (OW > 11) ? OW : 11;
   localparam int AW2 = ((OW > 10) ? OW : 10) + 1;

   req_type              req_ff;
   logic [CW-1:0]        head_ff, slots_ff;
   logic [OW-1:0]        used_ff, freed_ff;
   logic [HANDLE_SLOTS-1:0] live_ff;

   logic [OW-1:0]        off_mem  [HANDLE_SLOTS];
   logic [OW-1:0]        size_mem [HANDLE_SLOTS];
   logic [CW-1:0]        link_mem [HANDLE_SLOTS];
   logic [OW-1:0]        off_rd_ff, size_rd_ff;
   logic [CW-1:0]        link_rd_ff;

   logic [7:0]           store_mem [STORE_BYTES];
   logic [7:0]           store_rd_ff;

   logic [SAW-1:0]       fill_ptr_ff;
   logic [OW-1:0]        fill_left_ff;
   logic [HW-1:0]        scan_idx_ff, prev_h_ff, best_h_ff;
   logic [OW-1:0]        pos_ff, prev_off_ff, best_off_ff, best_size_ff, mv_k_ff;
   logic                 have_prev_ff, found_ff;

   logic [7:0]           res_handle_ff;
   logic [1:0]           res_status_ff;
   logic                 res_comp_ff, res_rd_ff;
   rsp_type              rsp_ff;
   logic                 rsp_strobe_ff;

   logic [HW-1:0]  hidx, slot, tab_addr;
   logic           h_range_ok, head_valid, no_space, no_handle, live_h, bad_off;
   logic [OW-1:0]  space, freed_new;
   logic [AW2-1:0] addr_sum;
   logic [1:0]     code;
   logic           skip, take;
   logic [SAW-1:0] st_addr;
   logic           st_we;
   logic [7:0]     st_wdata;

   assign hidx       = HW'(req_ff.handle);
   assign h_range_ok = 32'(req_ff.handle) < 32'(HANDLE_SLOTS);
   assign head_valid = head_ff < CW'(HANDLE_SLOTS);
   assign slot       = head_valid ? HW'(head_ff) : HW'(slots_ff);
   assign space      = OW'(STORE_BYTES) - used_ff;
   assign no_space   = EW'(req_ff.alloc_size) > EW'(space);
   assign no_handle  = !head_valid && (slots_ff == CW'(HANDLE_SLOTS));
   assign live_h     = h_range_ok && live_ff[hidx];
   assign addr_sum   = AW2'(off_rd_ff) + AW2'(req_ff.byte_offset);
   assign bad_off    = (AW2'(req_ff.byte_offset) >= AW2'(size_rd_ff)) ||
                       (addr_sum >= AW2'(STORE_BYTES));
   assign freed_new  = freed_ff + size_rd_ff;
   assign tab_addr   = cmd.scan_sel ? scan_idx_ff :
                       ((req_ff.action == ACT_ALLOC) ? HW'(head_ff) : hidx);

   always_comb begin
      priority if (req_ff.action == ACT_ALLOC) begin
         priority if (no_space) code = ST_NO_SPACE;
         else if (no_handle) code = ST_NO_HANDLE;
         else code = ST_OK;
      end else if (!live_h) begin
         code = ST_BAD;
      end else if (req_ff.action == ACT_FREE) begin
         code = ST_OK;
      end else if (bad_off) begin
         code = ST_BAD;
      end else begin
         code = ST_OK;
      end
   end

   assign skip = have_prev_ff && ((off_rd_ff < prev_off_ff) ||
                 ((off_rd_ff == prev_off_ff) && (scan_idx_ff <= prev_h_ff)));
   assign take = live_ff[scan_idx_ff] && !skip && (!found_ff || (off_rd_ff < best_off_ff));

   always_comb begin
      st_we    = cmd.fill_step || cmd.store_write || cmd.move_wr;
      st_wdata = cmd.move_wr ? store_rd_ff : (cmd.fill_step ? 8'd0 : req_ff.write_value);
      priority if (cmd.fill_step) st_addr = fill_ptr_ff;
      else if (cmd.move_rd) st_addr = SAW'(best_off_ff + mv_k_ff);
      else if (cmd.move_wr) st_addr = SAW'(pos_ff + mv_k_ff);
      else st_addr = SAW'(addr_sum);
   end

   always_comb begin
      stat.action      = req_ff.action;
      stat.code        = code;
      stat.size_zero   = (req_ff.alloc_size == 11'd0);
      stat.compact_hit = freed_new >= (used_ff >> 1);
      stat.scan_last   = (scan_idx_ff == HW'(HANDLE_SLOTS - 1));
      stat.found       = found_ff;
      stat.move_needed = (best_size_ff != '0) && (best_off_ff != pos_ff);
      stat.fill_last   = (fill_left_ff == OW'(1));
      stat.move_last   = (mv_k_ff == best_size_ff - OW'(1));
   end

   // handle tables
   always_ff @(posedge clock) begin
      if (cmd.commit_alloc) begin
         off_mem[slot] <= used_ff;
      end else if (cmd.place) begin
         off_mem[best_h_ff] <= pos_ff;
      end
      off_rd_ff <= off_mem[tab_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_alloc) begin
         size_mem[slot] <= OW'(req_ff.alloc_size);
      end else if (cmd.commit_free) begin
         size_mem[hidx] <= '0;
      end
      size_rd_ff <= size_mem[tab_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_free) begin
         link_mem[hidx] <= head_ff;
      end
      link_rd_ff <= link_mem[tab_addr];
   end

   // byte store
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_addr] <= st_wdata;
      end
      if (cmd.store_read || cmd.move_rd) begin
         store_rd_ff <= store_mem[st_addr];
      end
   end

   // allocator control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= CW'(HANDLE_SLOTS);
         slots_ff <= '0;
         used_ff  <= '0;
         freed_ff <= '0;
         live_ff  <= '0;
      end else begin
         if (cmd.commit_alloc) begin
            used_ff       <= used_ff + OW'(req_ff.alloc_size);
            live_ff[slot] <= 1'b1;
            if (head_valid) begin
               head_ff <= link_rd_ff;
            end else begin
               slots_ff <= slots_ff + CW'(1);
            end
         end
         if (cmd.commit_free) begin
            freed_ff      <= freed_new;
            live_ff[hidx] <= 1'b0;
            head_ff       <= CW'(hidx);
         end
         if (cmd.comp_done) begin
            used_ff  <= pos_ff;
            freed_ff <= '0;
         end
      end
   end

   // transaction, fill and compaction registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (cmd.check) begin
         res_status_ff <= code;
         res_handle_ff <= (req_ff.action == ACT_ALLOC && code == ST_OK) ? 8'(slot) : 8'd0;
         res_comp_ff   <= 1'b0;
         res_rd_ff     <= (req_ff.action == ACT_READ) && (code == ST_OK);
      end
      if (cmd.commit_alloc) begin
         fill_ptr_ff  <= SAW'(used_ff);
         fill_left_ff <= OW'(req_ff.alloc_size);
      end
      if (cmd.fill_step) begin
         fill_ptr_ff  <= fill_ptr_ff + SAW'(1);
         fill_left_ff <= fill_left_ff - OW'(1);
      end
      if (cmd.commit_free) begin
         scan_idx_ff  <= '0;
         pos_ff       <= '0;
         have_prev_ff <= 1'b0;
         found_ff     <= 1'b0;
         mv_k_ff      <= '0;
      end
      if (cmd.scan_cmp) begin
         scan_idx_ff <= scan_idx_ff + HW'(1);
         if (take) begin
            found_ff     <= 1'b1;
            best_off_ff  <= off_rd_ff;
            best_size_ff <= size_rd_ff;
            best_h_ff    <= scan_idx_ff;
         end
      end
      if (cmd.move_wr) begin
         mv_k_ff <= mv_k_ff + OW'(1);
      end
      if (cmd.place) begin
         pos_ff       <= pos_ff + best_size_ff;
         have_prev_ff <= 1'b1;
         prev_off_ff  <= best_off_ff;
         prev_h_ff    <= best_h_ff;
         found_ff     <= 1'b0;
         scan_idx_ff  <= '0;
         mv_k_ff      <= '0;
      end
      if (cmd.comp_done) begin
         res_comp_ff <= 1'b1;
      end
      if (cmd.respond) begin
         rsp_ff.new_handle <= res_handle_ff;
         rsp_ff.read_value <= res_rd_ff ? store_rd_ff : 8'd0;
         rsp_ff.status     <= res_status_ff;
         rsp_ff.compacted  <= res_comp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_used_fits: assert property (@(posedge clock) disable iff (reset)
      used_ff <= OW'(STORE_BYTES))
      else $error("used end beyond store");
   a_freed_le_used: assert property (@(posedge clock) disable iff (reset)
      freed_ff <= used_ff)
      else $error("freed total exceeds used end");
   a_slots_fit: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= CW'(HANDLE_SLOTS))
      else $error("slot count overflow");
   a_comp_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.comp_done |=> (freed_ff == '0) && (used_ff == pos_ff))
      else $error("compaction did not settle totals");

endmodule
